### hw/rtl/pas_pkg.sv
// ============================================================================
// pas_pkg
// Shared constants, tables and types for the partial amplitude shaper.
// ============================================================================
package pas_pkg;

    localparam int PARTIAL_COUNT = 5;
    localparam int PCOUNT = (PARTIAL_COUNT < 2) ? 2 :
                            ((PARTIAL_COUNT > 16) ? 16 : PARTIAL_COUNT);
    localparam int IDX_W = 4;
    localparam int QDEPTH = 2;

    typedef logic [IDX_W-1:0] idx_t;

    // log2(1 + i/(P-1)) in Q16, truncated; elaboration-time only
    function automatic logic [16:0] log2_const(input int i);
        logic [63:0] r;
        logic [16:0] res;
        res = '0;
        r = ((64'(PCOUNT - 1) + 64'(i)) << 30) / 64'(PCOUNT - 1);
        if (r >= (64'd1 << 31))
        begin
            res[16] = 1'b1;
            r = r >> 1;
        end
        for (int bt = 15; bt >= 0; bt--)
        begin
            r = (r * r) >> 30;
            if (r >= (64'd1 << 31))
            begin
                res[bt] = 1'b1;
                r = r >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic [16:0] log2_tab(input idx_t i);
        logic [16:0] v;
        v = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (k < PCOUNT && idx_t'(k) == i)
            begin
                v = log2_const(k);
            end
        end
        return v;
    endfunction

    function automatic logic [16:0] exp_tab(input logic [4:0] j);
        logic [16:0] v;
        unique case (j)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // one queued job: the exponent (Q16, up to 100.0) and a flag for b above one
    typedef struct packed {
        logic        neg;
        logic [22:0] a;
    } job_t;

endpackage

### hw/rtl/partial_amplitude_shaper.sv
// ============================================================================
// partial_amplitude_shaper
// Turns one spectral-shape value into normalized amplitudes for each partial.
// ============================================================================
// Usage:
//   s_axis carries one shape value b (unsigned Q1.15) per beat.
//   m_axis returns PCOUNT beats per input: tdata holds the amplitude in
//   Q1.15, tuser the partial index, tlast marks the final partial.
// Operation:
//   The front stage forms the exponent in registers s1 and s2 and queues
//   the job. The back part first computes the gain of every partial (one
//   multiply, one table interpolation each), then runs the normalizing
//   divide for each partial (start, quotient bits one a cycle, hand-off,
//   output); the divider sets the throughput. The front and the two-entry
//   queue keep accepting while the back works.
// Reset:
//   rst_n clears all handshake state; no results are pending afterwards.
// Stall:
//   When m_axis_tready is low the current beat holds and the back waits;
//   the queue then fills and s_axis_tready drops.
// ============================================================================
module partial_amplitude_shaper
    import pas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] shape_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] amplitude
    output logic [3:0]  m_axis_tuser,   // [3:0] partial_index
    output logic        m_axis_tlast
);

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    pas_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .shape_b   (s_axis_tdata),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    pas_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    pas_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (qb_valid),
        .job_ready     (qb_ready),
        .job           (qb_job),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .amplitude     (m_axis_tdata),
        .partial_index (m_axis_tuser),
        .last_partial  (m_axis_tlast)
    );

endmodule

### hw/rtl/pas_front.sv
// ============================================================================
// pas_front
// Accepts shape beats and forms the Q16 exponent a = 100*d*d in two stages.
// ============================================================================
module pas_front
    import pas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] shape_b,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic        s1_valid_reg;
    logic        s1_neg_reg;
    logic [31:0] s1_sq_reg;
    logic        s2_valid_reg;
    job_t        s2_job_reg;
    logic        s2_adv;
    logic        s1_adv;
    logic [15:0] d;
    logic [38:0] prod;

    assign s2_adv   = !s2_valid_reg || job_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;
    assign d        = 16'(17'd32768 - {1'b0, shape_b});
    assign prod     = 39'(s1_sq_reg) * 39'd100 + 39'd8192;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_neg_reg <= shape_b > 16'd32768;
            s1_sq_reg  <= 32'(d) * 32'(d);
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_job_reg.neg <= s1_neg_reg;
            s2_job_reg.a   <= 23'(prod >> 14);
        end
    end

    assign job_valid = s2_valid_reg;
    assign job       = s2_job_reg;

endmodule

### hw/rtl/pas_queue.sv
// ============================================================================
// pas_queue
// Short job queue between the front and back parts.
// ============================================================================
module pas_queue
    import pas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    job_t        mem_reg [QDEPTH];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr;
    logic        rd;

    assign wr_ready = cnt_reg != 2'(QDEPTH);
    assign rd_valid = cnt_reg != 2'd0;
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

endmodule

### hw/rtl/pas_div.sv
// ============================================================================
// pas_div
// Restoring divider: 16-bit quotient of a 33-bit dividend, one bit a cycle.
// ============================================================================
module pas_div
    import pas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [20:0] den,
    output logic        busy,
    output logic [15:0] quo
);

    logic [4:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [20:0] den_reg;
    logic [15:0] quo_reg;
    logic [37:0] trial;
    logic [37:0] dsh;

    assign busy  = cnt_reg != 5'd0;
    assign quo   = quo_reg;
    assign dsh   = 38'(den_reg) << (cnt_reg - 5'd1);
    assign trial = 38'(rem_reg) - dsh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else if (start)
        begin
            cnt_reg <= 5'd17;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    // quotient fits in 16 bits (at most 32768); bit 16 trial never succeeds
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            if (!trial[37])
            begin
                rem_reg <= 33'(trial);
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

endmodule

### hw/rtl/pas_back.sv
// ============================================================================
// pas_back
// Computes per-partial gains, their sum, then streams normalized amplitudes.
// ============================================================================
module pas_back
    import pas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] amplitude,
    output idx_t        partial_index,
    output logic        last_partial
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_EXP, ST_DSTART, ST_DWAIT, ST_OUT
    } state_t;

    state_t      st_reg;
    job_t        job_reg;
    idx_t        k_reg;
    logic [16:0] gain_reg [16];
    logic [20:0] sum_reg;
    logic [39:0] e_reg;
    logic        out_valid_reg;
    logic [15:0] amp_reg;
    idx_t        oidx_reg;
    logic        olast_reg;
    logic        dstart;
    logic        dbusy;
    logic [15:0] dquo;
    logic [32:0] dnum;
    logic [15:0] e16;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [28:0] ip;
    logic [16:0] g;
    logic [16:0] gk;
    logic        klast;
    logic        out_load;

    assign klast = k_reg == idx_t'(PCOUNT - 1);
    // e_reg holds E in Q16 above bit 16: integer part in [39:32], fraction in [31:16]
    assign e16   = e_reg[31:16];
    assign t0    = exp_tab({1'b0, e16[15:12]});
    assign t1    = exp_tab(5'({1'b0, e16[15:12]} + 5'd1));
    assign ip    = 29'(t0 - t1) * 29'(e16[11:0]) + 29'd2048;
    assign g     = (e_reg[39:32] >= 8'd17) ? 17'd0 :
                   17'((t0 - 17'(ip >> 12)) >> e_reg[36:32]);
    assign gk    = gain_reg[k_reg];
    assign dnum  = {gk, 15'd0} + 33'(sum_reg >> 1);
    assign dstart = st_reg == ST_DSTART;
    assign job_ready = st_reg == ST_IDLE;
    assign out_load  = (st_reg == ST_DWAIT) && !dbusy && (!out_valid_reg || out_ready);

    pas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (sum_reg),
        .busy  (dbusy),
        .quo   (dquo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        k_reg  <= '0;
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    st_reg <= ST_EXP;
                end
                ST_EXP:
                begin
                    if (klast)
                    begin
                        k_reg  <= '0;
                        st_reg <= ST_DSTART;
                    end
                    else
                    begin
                        k_reg  <= k_reg + idx_t'(1);
                        st_reg <= ST_MUL;
                    end
                end
                ST_DSTART:
                begin
                    st_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (out_load)
                    begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (klast)
                    begin
                        st_reg <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg  <= k_reg + idx_t'(1);
                        st_reg <= ST_DSTART;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && job_valid)
        begin
            job_reg <= job;
            sum_reg <= '0;
        end
        if (st_reg == ST_MUL)
        begin
            e_reg <= 40'(job_reg.a) * 40'(log2_tab(k_reg)) + 40'd32768;
        end
        if (st_reg == ST_EXP)
        begin
            if (job_reg.neg)
            begin
                gain_reg[k_reg] <= (k_reg == '0) ? 17'd65536 : 17'd0;
                sum_reg <= sum_reg + ((k_reg == '0) ? 21'd65536 : 21'd0);
            end
            else
            begin
                gain_reg[k_reg] <= g;
                sum_reg <= sum_reg + 21'(g);
            end
        end
        if (out_load)
        begin
            amp_reg   <= dquo;
            oidx_reg  <= k_reg;
            olast_reg <= klast;
        end
    end

    assign out_valid     = out_valid_reg;
    assign amplitude     = amp_reg;
    assign partial_index = oidx_reg;
    assign last_partial  = olast_reg;

endmodule
